// ===== hdl/abrb_pkg.sv =====
// abrb_pkg: shared types, constants and arithmetic helpers for the audio block ring buffer.
// No dependencies; used by abrb_store and audio_block_ring_buffer.
`default_nettype none

package abrb_pkg;

  // Store geometry. BLOCK_SIZE is a power of two; the store size is even.
  localparam int NUM_BLOCKS  = 4;
  localparam int BLOCK_SIZE  = 256;
  localparam int TOTAL_SLOTS = NUM_BLOCKS * BLOCK_SIZE;
  localparam int ADDR_W      = $clog2(TOTAL_SLOTS);
  localparam int OFS_W       = $clog2(BLOCK_SIZE);
  localparam int LOCK_W      = $clog2(NUM_BLOCKS);
  localparam int FREE_W      = ADDR_W + 1;
  localparam int BANK_DEPTH  = TOTAL_SLOTS / 2;
  localparam int ROW_W       = ADDR_W - 1;

  // Fixed field widths.
  localparam int SAMPLE_W    = 16;
  localparam int VOL_W       = 8;
  localparam int GAIN_SHIFT  = 8;
  localparam int PROD_W      = SAMPLE_W + VOL_W + 1;
  localparam int BLK_IDX_W   = 2;
  localparam int OUT_FREE_W  = 11;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CFG_IDX_W-1:0] REG_VOLUME = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MONO   = 1'd1;

  localparam logic [VOL_W-1:0]  VOLUME_RESET = 8'd255;
  localparam logic [LOCK_W-1:0] LOCK_RESET   = LOCK_W'(1);

  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_ADVANCE = 2'd1,
    CMD_READ    = 2'd2,
    CMD_RESET   = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t                        cmd;
    logic signed [SAMPLE_W-1:0]  sample;
    logic [7:0]                  offset;
  } in_item_t;

  typedef struct packed {
    logic                        accepted;
    logic [OUT_FREE_W-1:0]       free_space;
    logic [BLK_IDX_W-1:0]        block_index;
    logic signed [SAMPLE_W-1:0]  read_data;
  } out_item_t;

  // Slot write request: dual also writes the slot after addr (with wrap).
  typedef struct packed {
    logic                  en;
    logic                  dual;
    logic [ADDR_W-1:0]     addr;
    logic [SAMPLE_W-1:0]   data;
  } store_wr_t;

  // Writable slots between the write pointer and the start of the locked block.
  function automatic logic [FREE_W-1:0] free_slots(input logic [LOCK_W-1:0] lock,
                                                   input logic [ADDR_W-1:0] wp);
    logic [FREE_W-1:0] ls;
    logic [FREE_W-1:0] w;
    ls = FREE_W'(lock) * FREE_W'(BLOCK_SIZE);
    w  = FREE_W'(wp);
    if (ls < w) begin
      return FREE_W'(TOTAL_SLOTS) - w + ls;
    end
    return ls - w;
  endfunction

  // (sample * volume) >> 8, arithmetic shift.
  function automatic logic [SAMPLE_W-1:0] scale_sample(input logic signed [SAMPLE_W-1:0] s,
                                                       input logic [VOL_W-1:0] vol);
    logic signed [PROD_W-1:0] p;
    p = PROD_W'(s) * $signed({1'b0, vol});
    return p[GAIN_SHIFT+SAMPLE_W-1:GAIN_SHIFT];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/abrb_store.sv =====
// abrb_store: sample store split into even and odd banks so two adjacent slots
// can be written in the same cycle. Registered read. Depends on abrb_pkg.
`default_nettype none

module abrb_store
  import abrb_pkg::*;
(
  input  wire logic                 clk,
  input  wire store_wr_t            wr,
  input  wire logic                 rd_en,
  input  wire logic [ADDR_W-1:0]    rd_addr,
  output logic [SAMPLE_W-1:0]       rd_data
);

  logic [SAMPLE_W-1:0] mem_even [BANK_DEPTH];
  logic [SAMPLE_W-1:0] mem_odd  [BANK_DEPTH];

  logic [ADDR_W-1:0]   addr_b;
  logic                we_even;
  logic                we_odd;
  logic [ROW_W-1:0]    row_even;
  logic [ROW_W-1:0]    row_odd;
  logic [SAMPLE_W-1:0] q_even;
  logic [SAMPLE_W-1:0] q_odd;
  logic                rd_sel;

  // Second slot of a pair, wrapping at the end of the store.
  assign addr_b = (wr.addr == ADDR_W'(TOTAL_SLOTS - 1)) ? '0 : wr.addr + ADDR_W'(1);

  assign we_even  = wr.en && (!wr.addr[0] || wr.dual);
  assign we_odd   = wr.en && (wr.addr[0] || wr.dual);
  assign row_even = wr.addr[0] ? addr_b[ADDR_W-1:1] : wr.addr[ADDR_W-1:1];
  assign row_odd  = wr.addr[0] ? wr.addr[ADDR_W-1:1] : addr_b[ADDR_W-1:1];

  always_ff @(posedge clk) begin
    if (we_even) begin
      mem_even[row_even] <= wr.data;
    end
    if (we_odd) begin
      mem_odd[row_odd] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      q_even <= mem_even[rd_addr[ADDR_W-1:1]];
      q_odd  <= mem_odd[rd_addr[ADDR_W-1:1]];
      rd_sel <= rd_addr[0];
    end
  end

  assign rd_data = rd_sel ? q_odd : q_even;

endmodule

`default_nettype wire

// ===== hdl/audio_block_ring_buffer.sv =====
// audio_block_ring_buffer: top level; command decode, pointers, result register.
// Depends on abrb_pkg and abrb_store.
`default_nettype none

// Takes one command word per clock while in_stall is low and returns one result
// word for each, in the cycle after it is taken. Write, advance, read and
// pointer-reset all finish in a single pass; the store is split into even and
// odd banks so a mono write lands both copies in the same cycle, and reads come
// from the registered bank output. After reset the block stalls its input while
// it zeroes the store, row by row; configuration writes are taken at any time.
// Volume and mono mode should be changed only while no command is in flight.
module audio_block_ring_buffer
  import abrb_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_item_t              in_word,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_word,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic [VOL_W-1:0]       volume;
  logic                   mono_mode;
  logic [ADDR_W-1:0]      write_pos;
  logic [LOCK_W-1:0]      locked_block;
  logic                   clr_busy;
  logic [ROW_W-1:0]       clr_row;

  logic                   in_acc;
  logic [ADDR_W-1:0]      write_pos_next;
  logic [LOCK_W-1:0]      locked_block_next;
  logic                   ok_next;
  logic                   wr_ok;
  logic [FREE_W-1:0]      free_now;
  logic [FREE_W-1:0]      free_next;
  logic [ADDR_W:0]        wp_sum;
  logic [LOCK_W-1:0]      lock_step;
  logic [FREE_W-1:0]      nstart;
  logic [FREE_W-1:0]      nend;
  logic [ADDR_W-1:0]      ofs_masked;
  store_wr_t              item_wr;
  store_wr_t              wr_req;
  logic                   rd_en;
  logic [ADDR_W-1:0]      rd_addr;
  logic [SAMPLE_W-1:0]    rd_data;

  logic                   res_accepted;
  logic [FREE_W-1:0]      res_free;
  logic [LOCK_W-1:0]      res_lock;
  logic                   res_is_read;

  assign in_stall = clr_busy || (out_valid && out_stall);
  assign in_acc   = in_valid && !in_stall;

  // Command decode and pointer update.
  always_comb begin
    write_pos_next    = write_pos;
    locked_block_next = locked_block;
    ok_next           = 1'b1;
    free_now          = free_slots(locked_block, write_pos);
    wr_ok             = free_now >= (mono_mode ? FREE_W'(2) : FREE_W'(1));
    wp_sum            = (ADDR_W+1)'(write_pos) + (mono_mode ? (ADDR_W+1)'(2) : (ADDR_W+1)'(1));
    if (wp_sum >= (ADDR_W+1)'(TOTAL_SLOTS)) begin
      wp_sum = wp_sum - (ADDR_W+1)'(TOTAL_SLOTS);
    end
    lock_step = (locked_block == LOCK_W'(NUM_BLOCKS - 1)) ? '0 : locked_block + LOCK_W'(1);
    nstart    = FREE_W'(lock_step) * FREE_W'(BLOCK_SIZE);
    nend      = nstart + FREE_W'(BLOCK_SIZE);
    item_wr.en   = 1'b0;
    item_wr.dual = mono_mode;
    item_wr.addr = write_pos;
    item_wr.data = scale_sample(in_word.sample, volume);
    rd_en        = 1'b0;
    case (in_word.cmd)
      CMD_WRITE: begin
        if (wr_ok) begin
          item_wr.en     = in_acc;
          write_pos_next = wp_sum[ADDR_W-1:0];
        end else begin
          ok_next = 1'b0;
        end
      end
      CMD_ADVANCE: begin
        // Refuse when the writer sits inside the next block, upper edge included.
        if (FREE_W'(write_pos) >= nstart && FREE_W'(write_pos) <= nend) begin
          ok_next = 1'b0;
        end else begin
          locked_block_next = lock_step;
        end
      end
      CMD_READ: begin
        rd_en = in_acc;
      end
      CMD_RESET: begin
        write_pos_next    = '0;
        locked_block_next = LOCK_RESET;
      end
      default: begin
        ok_next = 1'b0;
      end
    endcase
    free_next = free_slots(locked_block_next, write_pos_next);
  end

  assign ofs_masked = ADDR_W'(in_word.offset) & ADDR_W'(BLOCK_SIZE - 1);
  assign rd_addr    = ADDR_W'(locked_block) * ADDR_W'(BLOCK_SIZE) + ofs_masked;

  // Clearing sweep zeroes one row of both banks per cycle.
  always_comb begin
    if (clr_busy) begin
      wr_req.en   = 1'b1;
      wr_req.dual = 1'b1;
      wr_req.addr = {clr_row, 1'b0};
      wr_req.data = '0;
    end else begin
      wr_req = item_wr;
    end
  end

  abrb_store u_store (
    .clk     (clk),
    .wr      (wr_req),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_row  <= '0;
    end else if (clr_busy) begin
      clr_row <= clr_row + ROW_W'(1);
      if (clr_row == ROW_W'(BANK_DEPTH - 1)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      volume    <= VOLUME_RESET;
      mono_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_VOLUME: volume    <= cfg_data;
        REG_MONO:   mono_mode <= cfg_data[0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pos    <= '0;
      locked_block <= LOCK_RESET;
      out_valid    <= 1'b0;
    end else begin
      if (in_acc) begin
        write_pos    <= write_pos_next;
        locked_block <= locked_block_next;
        out_valid    <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result word; hold while the output is stalled.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_accepted <= ok_next;
      res_free     <= free_next;
      res_lock     <= locked_block_next;
      res_is_read  <= (in_word.cmd == CMD_READ);
    end
  end

  always_comb begin
    out_word.accepted    = res_accepted;
    out_word.free_space  = OUT_FREE_W'(res_free);
    out_word.block_index = BLK_IDX_W'(res_lock);
    out_word.read_data   = res_is_read ? rd_data : '0;
  end

  a_clear_stalls: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> in_stall)
    else $error("input taken during store clearing");

  a_lock_range: assert property (@(posedge clk) disable iff (rst)
    LOCK_W'(locked_block) <= LOCK_W'(NUM_BLOCKS - 1))
    else $error("locked block out of range");

  a_free_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (res_free <= FREE_W'(TOTAL_SLOTS)))
    else $error("free space beyond store size");

  a_no_write_in_lock: assert property (@(posedge clk) disable iff (rst)
    (wr_req.en && !clr_busy) |-> (wr_req.addr[ADDR_W-1:OFS_W] != locked_block))
    else $error("write lands in locked block");

  a_refused_write_holds: assert property (@(posedge clk) disable iff (rst)
    (in_acc && in_word.cmd == CMD_WRITE && !wr_ok) |=> $stable(write_pos))
    else $error("refused write moved the write pointer");

endmodule

`default_nettype wire
